[sv/pipt_pkg.sv]
package pipt_pkg;

  localparam int unsigned TILE_WIDTH = 8;
  localparam int unsigned COL_W      = $clog2(TILE_WIDTH);
  localparam int unsigned PLANES     = 4;

  typedef enum logic [1:0] {
    OP_BUILD  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ROW    = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_index;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  plane_zero;
    logic [7:0]  plane_one;
    logic [7:0]  plane_two;
    logic [7:0]  plane_three;
    logic [14:0] color_word;
    logic [8:0]  color_count;
    logic        table_full;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_issue;
    logic rd_emit;
    logic search_init;
    logic search_run;
    logic build_commit;
    logic encode_commit;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic search_done;
  } sts_t;

  function automatic logic [14:0] color_word_of(input logic [23:0] rgb);
    logic [14:0] w;
    w[3:0]   = rgb[23:20];
    w[7:4]   = rgb[15:12];
    w[11:8]  = rgb[7:4];
    w[12]    = rgb[19];
    w[13]    = rgb[11];
    w[14]    = rgb[3];
    return w;
  endfunction

endpackage

[sv/palette_index_planar_tile_pack_core.sv]
// Channel   | Handshake               | Payload
// ----------+-------------------------+--------------------------
// request   | start / busy            | req_i (pipt_pkg::req_t)
// result    | result_valid_o strobe   | result_o (pipt_pkg::rsp_t)
// config    | cfg_we_i                | cfg_wdata_i (ext_mode)
//
// Build and encode scan the stored colors (up to PALETTE_DEPTH) one entry a cycle
// on the palette memory's read port. The result strobe rises at the edge where busy falls.
// Reset is asynchronous, active low; it empties the palette and the row being packed.
// Results last one cycle; the receiver cannot stall them.
module palette_index_planar_tile_pack_core #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pipt_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  output logic           result_valid_o,
  output pipt_pkg::rsp_t result_o
);
  import pipt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pipt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pipt_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[sv/pipt_ctrl.sv]
module pipt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pipt_pkg::sts_t sts_i,
  output pipt_pkg::cmd_t cmd_o
);
  import pipt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_RDWAIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_BUILD, OP_ENCODE: begin
            cmd_o.search_init = 1'b1;
            state_d           = S_SEARCH;
          end
          OP_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = S_RDWAIT;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        if (sts_i.search_done) begin
          if (sts_i.op == OP_BUILD) begin
            cmd_o.build_commit = 1'b1;
          end else begin
            cmd_o.encode_commit = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          cmd_o.search_run = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_emit = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_search_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> (sts_i.op == OP_BUILD || sts_i.op == OP_ENCODE))
    else $error("search running for an op without lookup");

endmodule

[sv/pipt_datapath.sv]
module pipt_datapath #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  pipt_pkg::req_t req_i,
  input  pipt_pkg::cmd_t cmd_i,
  output pipt_pkg::sts_t sts_o,
  output logic           result_valid_o,
  output pipt_pkg::rsp_t result_o
);
  import pipt_pkg::*;

  localparam int unsigned IDXW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW   = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned SW   = (CW > 8) ? CW : 8;

  logic [23:0] mem [PALETTE_DEPTH];

  logic                ext_q;
  op_e                 op_q;
  logic [23:0]         rgb_q;
  logic [7:0]          sel_q;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       ptr_q;
  logic                pend_q;
  logic [IDXW-1:0]     pend_addr_q;
  logic                found_q;
  logic [IDXW-1:0]     hit_idx_q;
  logic [23:0]         rd_data_q;
  logic [COL_W-1:0]    col_q;
  logic [PLANES*TILE_WIDTH-1:0] acc_q, acc_new;
  logic                result_valid_q;
  rsp_t                result_q, result_d;

  logic                issue_search, rd_en, hit_now, mem_we, room;
  logic [IDXW-1:0]     rd_addr;
  logic [IDXW-1:0]     ext_idx;
  logic [PLANES-1:0]   val;
  logic                row_done;

  assign room         = count_q < CW'(PALETTE_DEPTH);
  assign issue_search = cmd_i.search_run && !found_q && (ptr_q < count_q);
  assign rd_en        = cmd_i.rd_issue || issue_search;
  assign rd_addr      = cmd_i.rd_issue ? IDXW'(sel_q) : ptr_q[IDXW-1:0];
  assign hit_now      = pend_q && !found_q && (rd_data_q == rgb_q);
  assign mem_we       = cmd_i.build_commit && !found_q && room;

  assign sts_o.op          = op_q;
  assign sts_o.search_done = !pend_q && (found_q || (ptr_q >= count_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IDXW-1:0]] <= rgb_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign ext_idx = hit_idx_q - IDXW'(15);

  always_comb begin
    val = '0;
    if (found_q) begin
      if (!ext_q && (hit_idx_q < 16)) begin
        val = hit_idx_q[3:0];
      end else if (ext_q && (hit_idx_q > 15)) begin
        val = ext_idx[3:0];
      end
    end
    acc_new = acc_q;
    for (int k = 0; k < PLANES; k++) begin
      acc_new[TILE_WIDTH*k + int'(col_q)] = acc_q[TILE_WIDTH*k + int'(col_q)] | val[k];
    end
  end

  assign row_done = (col_q == COL_W'(TILE_WIDTH - 1));
  assign count_d  = (!found_q && room) ? count_q + 1'b1 : count_q;

  always_comb begin
    result_d = '0;
    if (cmd_i.build_commit) begin
      result_d.kind        = KIND_STATUS;
      result_d.color_count = 9'(count_d);
      result_d.table_full  = !found_q && !room;
    end else if (cmd_i.encode_commit) begin
      result_d.kind        = KIND_ROW;
      result_d.plane_zero  = acc_new[7:0];
      result_d.plane_one   = acc_new[15:8];
      result_d.plane_two   = acc_new[23:16];
      result_d.plane_three = acc_new[31:24];
      result_d.color_count = 9'(count_q);
    end else begin
      result_d.kind        = KIND_WORD;
      result_d.color_count = 9'(count_q);
      if (SW'(sel_q) < SW'(count_q)) begin
        result_d.color_word = color_word_of(rd_data_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q          <= 1'b0;
      count_q        <= '0;
      ptr_q          <= '0;
      pend_q         <= 1'b0;
      found_q        <= 1'b0;
      col_q          <= '0;
      acc_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.build_commit || (cmd_i.encode_commit && row_done) ||
                        cmd_i.rd_emit;
      if (cfg_we_i) begin
        ext_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.search_init) begin
        ptr_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else begin
        pend_q <= issue_search;
        if (issue_search) begin
          ptr_q <= ptr_q + 1'b1;
        end
        if (hit_now) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.build_commit) begin
        count_q <= count_d;
      end
      if (cmd_i.encode_commit) begin
        if (row_done) begin
          acc_q <= '0;
          col_q <= '0;
        end else begin
          acc_q <= acc_new;
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i.op;
      rgb_q <= {req_i.red, req_i.green, req_i.blue};
      sel_q <= req_i.entry_index;
    end
    if (issue_search) begin
      pend_addr_q <= ptr_q[IDXW-1:0];
    end
    if (hit_now) begin
      hit_idx_q <= pend_addr_q;
    end
    if (cmd_i.build_commit || (cmd_i.encode_commit && row_done) || cmd_i.rd_emit) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PALETTE_DEPTH))
    else $error("entry count beyond palette depth");

  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CW'(pend_addr_q) < count_q))
    else $error("lookup read outside filled entries");

  a_row_resets_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && (result_q.kind == KIND_ROW) |-> (col_q == '0) && (acc_q == '0))
    else $error("row emitted without restarting the column");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe longer than one cycle");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import pipt_pkg::*;

  localparam int unsigned PAL_DEPTH     = 256;
  localparam int unsigned ITEM_TARGET   = 1650;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 4000;

  typedef enum logic [1:0] {
    CMD_REQ,
    CMD_MODE,
    CMD_HOLD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    req_t      req;
    logic      mode;
  } palette_cmd_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  logic busy;
  req_t req_i       = '0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic result_valid_o;
  rsp_t result_o;

  palette_cmd_t cmd_q[$];
  rsp_t         rsp_due_q[$];
  int unsigned  fail_cnt = 0;
  int unsigned  n_items  = 0;

  // predictor state
  logic [23:0]      pal_mem [PAL_DEPTH];
  int unsigned      pal_fill = 0;
  logic [COL_W-1:0] pix_col  = '0;
  logic [7:0]       row_bits [PLANES] = '{default: '0};
  logic             pack_ext = 1'b0;

  // stimulus-side palette mirror
  logic [23:0] gen_pal[$];
  int unsigned gen_hw  = 0;
  logic        gen_ext = 1'b0;

  int unsigned  gap_left   = 0;
  int unsigned  burst_left = 0;
  int unsigned  settle_cnt = 0;
  int unsigned  stall_cnt  = 0;
  logic         nx_start, nx_we, nx_wd;
  req_t         nx_req;
  rsp_t         rsp_want;

  palette_index_planar_tile_pack_core #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .result_valid_o,
    .result_o
  );

  always #4 clk_i = ~clk_i;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic predict_cmd(input req_t r);
    rsp_t        rsp;
    logic [23:0] rgb, c;
    bit          hit, full;
    int unsigned hit_idx;
    logic [3:0]  code;
    rsp     = '0;
    rgb     = {r.red, r.green, r.blue};
    hit     = 1'b0;
    full    = 1'b0;
    hit_idx = 0;
    code    = '0;
    for (int i = 0; i < int'(pal_fill); i++) begin
      if (!hit && pal_mem[i] == rgb) begin
        hit     = 1'b1;
        hit_idx = i;
      end
    end
    case (r.op)
      OP_BUILD: begin
        if (!hit) begin
          if (pal_fill < PAL_DEPTH) begin
            pal_mem[pal_fill] = rgb;
            pal_fill++;
          end else begin
            full = 1'b1;
          end
        end
        rsp.kind        = KIND_STATUS;
        rsp.color_count = 9'(pal_fill);
        rsp.table_full  = full;
        rsp_due_q.push_back(rsp);
      end
      OP_ENCODE: begin
        if (hit && !pack_ext && hit_idx < 16) code = hit_idx[3:0];
        else if (hit && pack_ext && hit_idx > 15) code = 4'(hit_idx - 15);
        for (int k = 0; k < PLANES; k++) row_bits[k][pix_col] = row_bits[k][pix_col] | code[k];
        if (pix_col == COL_W'(TILE_WIDTH - 1)) begin
          rsp.kind        = KIND_ROW;
          rsp.plane_zero  = row_bits[0];
          rsp.plane_one   = row_bits[1];
          rsp.plane_two   = row_bits[2];
          rsp.plane_three = row_bits[3];
          rsp.color_count = 9'(pal_fill);
          rsp_due_q.push_back(rsp);
          for (int k = 0; k < PLANES; k++) row_bits[k] = '0;
          pix_col = '0;
        end else begin
          pix_col = pix_col + 1'b1;
        end
      end
      OP_READ: begin
        if (r.entry_index < pal_fill) begin
          c = pal_mem[r.entry_index];
          rsp.color_word = {c[3], c[11], c[19], c[7:4], c[15:12], c[23:20]};
        end
        rsp.kind        = KIND_WORD;
        rsp.color_count = 9'(pal_fill);
        rsp_due_q.push_back(rsp);
      end
      default: begin
        pal_fill = 0;
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 4) begin
      burst_left = $urandom_range(16, 64);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic push_op(input op_e op, input logic [23:0] rgb, input logic [7:0] sel);
    palette_cmd_t cmd;
    bit           known;
    cmd                 = '0;
    cmd.kind            = CMD_REQ;
    cmd.req.op          = op;
    cmd.req.red         = rgb[23:16];
    cmd.req.green       = rgb[15:8];
    cmd.req.blue        = rgb[7:0];
    cmd.req.entry_index = sel;
    known               = 1'b0;
    if (op == OP_BUILD) begin
      foreach (gen_pal[i]) if (gen_pal[i] == rgb) known = 1'b1;
      if (!known && gen_pal.size() < PAL_DEPTH) gen_pal.push_back(rgb);
      if (gen_pal.size() > gen_hw) gen_hw = gen_pal.size();
    end
    if (op == OP_CLEAR) gen_pal.delete();
    cmd_q.push_back(cmd);
    n_items++;
  endtask

  task automatic push_ctrl(input cmd_kind_e kind, input logic mode);
    palette_cmd_t cmd;
    cmd      = '0;
    cmd.kind = kind;
    cmd.mode = mode;
    if (kind == CMD_MODE) gen_ext = mode;
    cmd_q.push_back(cmd);
  endtask

  function automatic logic [23:0] pick_pixel();
    int unsigned n, roll;
    n    = gen_pal.size();
    roll = $urandom_range(99);
    if (n == 0 || roll < 12) return 24'($urandom);
    if (roll < 16) return 24'h000000;
    if (!gen_ext && roll < 70) return gen_pal[$urandom_range((n < 16) ? n - 1 : 15)];
    return gen_pal[$urandom_range(n - 1)];
  endfunction

  initial begin
    int unsigned phase, roll, n_ops, full_runs;
    phase     = 0;
    full_runs = 0;

    push_op(OP_ENCODE, 24'h000000, 8'hFF);
    push_op(OP_BUILD,  24'h000000, 8'h00);
    push_op(OP_BUILD,  24'h000000, 8'hFF);
    push_op(OP_BUILD,  24'hFFFFFF, 8'h00);
    push_op(OP_BUILD,  24'h0F0F0F, 8'h00);
    push_op(OP_BUILD,  24'hF80801, 8'h00);
    push_op(OP_READ,   24'hFFFFFF, 8'h00);
    push_op(OP_READ,   24'h000000, 8'h01);
    push_op(OP_READ,   24'h000000, 8'h02);
    push_op(OP_READ,   24'h000000, 8'h03);
    push_op(OP_ENCODE, 24'hFFFFFF, 8'h00);
    push_op(OP_ENCODE, 24'h0F0F0F, 8'h00);
    push_op(OP_ENCODE, 24'h123456, 8'h00);
    push_op(OP_ENCODE, 24'hF80801, 8'h00);
    push_op(OP_ENCODE, 24'h000000, 8'h00);
    push_op(OP_ENCODE, 24'hFFFFFF, 8'h00);
    push_op(OP_ENCODE, 24'h0F0F0F, 8'hFF);
    push_op(OP_CLEAR,  24'hFFFFFF, 8'hFF);
    push_op(OP_READ,   24'h000000, 8'h01);
    push_op(OP_ENCODE, 24'hFFFFFF, 8'h00);
    push_op(OP_BUILD,  24'hFFFFFF, 8'h00);
    push_op(OP_ENCODE, 24'hFFFFFF, 8'h00);
    push_op(OP_CLEAR,  24'h000000, 8'h00);

    while (n_items < ITEM_TARGET) begin
      if (phase == 3) push_ctrl(CMD_HOLD, 1'b0);
      if (phase < 4) push_ctrl(CMD_MODE, phase[0]);
      else if ($urandom_range(1) == 1) push_ctrl(CMD_MODE, 1'($urandom));

      roll = $urandom_range(99);
      if (phase == 1 || (roll < 3 && full_runs < 3)) begin
        push_op(OP_CLEAR, 24'($urandom), 8'($urandom));
        while (gen_pal.size() < PAL_DEPTH) push_op(OP_BUILD, 24'($urandom), 8'($urandom));
        repeat (4) push_op(OP_BUILD, 24'($urandom), 8'($urandom));
        full_runs++;
      end else if (roll < 45) begin
        push_op(OP_CLEAR, 24'($urandom), 8'($urandom));
        n_ops = ($urandom_range(3) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 24);
        repeat (n_ops) push_op(OP_BUILD, 24'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(0, 6)) push_op(OP_BUILD, 24'($urandom), 8'($urandom));
      end

      n_ops = $urandom_range(8, 30);
      repeat (n_ops) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          repeat (($urandom_range(3) == 0) ? $urandom_range(1, 7) : 8)
            push_op(OP_ENCODE, pick_pixel(), 8'($urandom));
        end else if (roll < 70) begin
          push_op(OP_BUILD, ($urandom_range(1) == 1) ? pick_pixel() : 24'($urandom),
                  8'($urandom));
        end else if (roll < 90) begin
          if (gen_hw != 0) push_op(OP_READ, 24'($urandom), 8'($urandom_range(gen_hw - 1)));
        end else if (roll < 94) begin
          push_op(OP_CLEAR, 24'($urandom), 8'($urandom));
        end else begin
          push_op(OP_ENCODE, 24'($urandom), 8'($urandom));
        end
      end
      phase++;
    end

    do @(negedge clk_i); while (cmd_q.size() != 0 || start || rsp_due_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      req_i       <= '0;
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= 1'b0;
      gap_left    = 0;
      settle_cnt  = 0;
    end else begin
      nx_start = start;
      nx_req   = req_i;
      nx_we    = 1'b0;
      nx_wd    = cfg_wdata_i;
      if (start && !busy) begin
        predict_cmd(req_i);
        nx_start = 1'b0;
        gap_left = pick_gap();
      end
      if (!nx_start && cmd_q.size() != 0) begin
        if (cmd_q[0].kind == CMD_REQ) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            nx_req   = cmd_q[0].req;
            nx_start = 1'b1;
            cmd_q.delete(0);
          end
        end else if (busy || result_valid_o || rsp_due_q.size() != 0) begin
          settle_cnt = 0;
        end else if (settle_cnt < SETTLE_CYCLES) begin
          settle_cnt++;
        end else begin
          if (cmd_q[0].kind == CMD_MODE) begin
            nx_we    = 1'b1;
            nx_wd    = cmd_q[0].mode;
            pack_ext = cmd_q[0].mode;
          end
          settle_cnt = 0;
          cmd_q.delete(0);
        end
      end
      start       <= nx_start;
      req_i       <= nx_req;
      cfg_we_i    <= nx_we;
      cfg_wdata_i <= nx_wd;
    end
  end

  task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s expected %0h actual %0h", $time, tag, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (rsp_due_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: transfer with none due, expected none, actual %p", $time, result_o);
        end else begin
          rsp_want = rsp_due_q.pop_front();
          check_field("kind",        32'(rsp_want.kind),        32'(result_o.kind));
          check_field("plane_zero",  32'(rsp_want.plane_zero),  32'(result_o.plane_zero));
          check_field("plane_one",   32'(rsp_want.plane_one),   32'(result_o.plane_one));
          check_field("plane_two",   32'(rsp_want.plane_two),   32'(result_o.plane_two));
          check_field("plane_three", 32'(rsp_want.plane_three), 32'(result_o.plane_three));
          check_field("color_word",  32'(rsp_want.color_word),  32'(result_o.color_word));
          check_field("color_count", 32'(rsp_want.color_count), 32'(result_o.color_count));
          check_field("table_full",  32'(rsp_want.table_full),  32'(result_o.table_full));
        end
      end
      if ((start && !busy) || result_valid_o || cfg_we_i) begin
        stall_cnt = 0;
      end else if (stall_cnt == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cnt++;
      end
    end
  end

endmodule
